/* sv/julia_escape_time_pixel_macros.svh */
// Assertion macros for the Julia escape-time pixel block.
// Included by the RTL files that carry concurrent assertions.
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication
`define JETP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jetp assertion failed");

// next-cycle implication
`define JETP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jetp assertion failed");

`endif

/* sv/jetp_pkg.sv */
// Package for the Julia escape-time pixel block: widths, reset values,
// register indexes and payload types. No dependencies.
`timescale 1ns / 1ps

package jetp_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRAC_BITS     = 28;
   localparam int COORD_BITS    = 12;
   localparam int ITER_BITS     = 16;
   localparam int QUOT_BITS     = 8;
   localparam int REM_BITS      = ITER_BITS + 10;
   localparam int CSR_ADDR_BITS = 3;

   localparam int RESET_MIN_REAL  = -322122547;
   localparam int RESET_MAX_IMAG  = 402653184;
   localparam int RESET_REAL_STEP = 0;
   localparam int RESET_IMAG_STEP = 0;
   localparam int RESET_K_REAL    = 80530637;
   localparam int RESET_K_IMAG    = 131533373;
   localparam int RESET_MAX_ITER  = 100;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_MIN_REAL  = 3'd0,
      REG_MAX_IMAG  = 3'd1,
      REG_REAL_STEP = 3'd2,
      REG_IMAG_STEP = 3'd3,
      REG_K_REAL    = 3'd4,
      REG_K_IMAG    = 3'd5,
      REG_MAX_ITER  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic                 inside_res;
      logic [ITER_BITS-1:0] escape_count;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } core_ctl_type;

   typedef struct packed {
      logic escape;
   } core_sts_type;

endpackage

/* sv/jetp_div_cell.sv */
// One cell of the colour divider chain: settles one quotient bit and
// hands remainder and partial quotient to the next cell. Uses jetp_pkg.
`timescale 1ns / 1ps

module jetp_div_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  logic [jetp_pkg::REM_BITS-1:0] rem_in,
   input  logic [jetp_pkg::QUOT_BITS-1:0] quot_in,
   input  logic [jetp_pkg::ITER_BITS-1:0] den,
   output logic                          valid_out,
   output logic [jetp_pkg::REM_BITS-1:0] rem_out,
   output logic [jetp_pkg::QUOT_BITS-1:0] quot_out
);

   localparam int RW = jetp_pkg::REM_BITS;
   localparam int QW = jetp_pkg::QUOT_BITS;

   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in_nxt;
   logic [QW-1:0] quot_ff, quot_in_nxt;
   logic [RW:0]   trial;

   always_comb begin
      trial = {1'b0, rem_in} - ((RW + 1)'(den) << BIT_POS);
      if (!trial[RW]) begin
         rem_in_nxt  = trial[RW-1:0];
         quot_in_nxt = quot_in | (QW'(1) << BIT_POS);
      end else begin
         rem_in_nxt  = rem_in;
         quot_in_nxt = quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff  <= rem_in_nxt;
      quot_ff <= quot_in_nxt;
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign quot_out  = quot_ff;

endmodule

/* sv/jetp_core.sv */
// Iteration datapath: holds z, registers the squares and cross product,
// and forms the saturated z^2 + k. Uses jetp_pkg control types.
`timescale 1ns / 1ps

module jetp_core #(
   parameter int DATA_WIDTH = jetp_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = jetp_pkg::FRAC_BITS
) (
   input  logic                         clock,
   input  jetp_pkg::core_ctl_type       ctl,
   input  logic signed [DATA_WIDTH-1:0] z0_real,
   input  logic signed [DATA_WIDTH-1:0] z0_imag,
   input  logic signed [DATA_WIDTH-1:0] k_real,
   input  logic signed [DATA_WIDTH-1:0] k_imag,
   output jetp_pkg::core_sts_type       sts
);

   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;
   localparam int NW = 2 * DW + 2;
   localparam int CW = (2 * DW + 2 > 2 * FRAC_BITS + 4) ? 2 * DW + 2 : 2 * FRAC_BITS + 4;
   localparam logic [CW-1:0] LIMIT = CW'(4) << (2 * FRAC_BITS);
   localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW - 1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW - 1){1'b0}}};

   logic signed [DW-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic [DW-1:0]        ar, ai;
   logic [PW-1:0]        r2_ff, i2_ff;
   logic signed [PW-1:0] ri_ff;
   logic [CW-1:0]        mag;
   logic signed [NW-1:0] diff, nr_wide, ni_wide;
   logic signed [DW-1:0] nr_sat, ni_sat;

   always_comb begin
      ar = zr_ff[DW-1] ? DW'(-zr_ff) : DW'(zr_ff);
      ai = zi_ff[DW-1] ? DW'(-zi_ff) : DW'(zi_ff);
      mag = CW'(r2_ff) + CW'(i2_ff);
      diff = $signed(NW'(r2_ff)) - $signed(NW'(i2_ff));
      nr_wide = (diff >>> FRAC_BITS) + NW'(k_real);
      ni_wide = (NW'(ri_ff) >>> (FRAC_BITS - 1)) + NW'(k_imag);
      if (&nr_wide[NW-1:DW-1] || ~|nr_wide[NW-1:DW-1]) begin
         nr_sat = nr_wide[DW-1:0];
      end else begin
         nr_sat = nr_wide[NW-1] ? SAT_MIN : SAT_MAX;
      end
      if (&ni_wide[NW-1:DW-1] || ~|ni_wide[NW-1:DW-1]) begin
         ni_sat = ni_wide[DW-1:0];
      end else begin
         ni_sat = ni_wide[NW-1] ? SAT_MIN : SAT_MAX;
      end
      priority if (ctl.load) begin
         zr_in = z0_real;
         zi_in = z0_imag;
      end else if (ctl.step) begin
         zr_in = nr_sat;
         zi_in = ni_sat;
      end else begin
         zr_in = zr_ff;
         zi_in = zi_ff;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff <= zr_in;
      zi_ff <= zi_in;
      r2_ff <= PW'(ar) * PW'(ar);
      i2_ff <= PW'(ai) * PW'(ai);
      ri_ff <= PW'(zr_ff) * PW'(zi_ff);
   end

   assign sts.escape = mag > LIMIT;

endmodule

/* sv/julia_escape_time_pixel.sv */
// Top level of the Julia escape-time pixel block: registers, sequencer,
// start-point arithmetic and the divider chain. Uses jetp_pkg, jetp_core,
// jetp_div_cell and the assertion macro header.
//
// Usage:
//   Write the seven registers on the csr_ port (index 0..6) while idle.
//   Present a pixel on req_data with req_valid; it is taken when req_ready
//   is high. One result per pixel leaves on rsp_data under rsp_valid and
//   is held until rsp_ready.
// Per pixel: S_COORD and S_LOAD form and load the start point; each escape
//   test is the multiplier stage (S_MUL), then test and update (S_CHK);
//   an escaped point then passes the 8-cell divider chain, and S_OUT loads
//   the output register once it is free.
// Throughput: one pixel at a time; the iteration loop of the multiplier
//   stage sets the rate. The next pixel is taken while a result waits.
// Reset: registers return to their default view and constant, the
//   sequencer idles, no result is pending.
// Stall: a result held by the receiver blocks only its own transfer; a
//   following pixel completes its work and waits until the output frees.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_macros.svh"

module julia_escape_time_pixel #(
   parameter int DATA_WIDTH = jetp_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = jetp_pkg::FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  jetp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output jetp_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [jetp_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [((DATA_WIDTH > jetp_pkg::ITER_BITS) ? DATA_WIDTH : jetp_pkg::ITER_BITS)-1:0]
                                                csr_wdata
);

   localparam int DW = DATA_WIDTH;
   localparam int CB = jetp_pkg::COORD_BITS;
   localparam int IB = jetp_pkg::ITER_BITS;
   localparam int QW = jetp_pkg::QUOT_BITS;
   localparam int RW = jetp_pkg::REM_BITS;
   localparam int PW = DW + CB + 1;
   localparam int SW = PW + 1;
   localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW - 1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW - 1){1'b0}}};

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_COORD = 7'b0000010,
      S_LOAD  = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_CHK   = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [DW-1:0] min_real_ff, max_imag_ff, real_step_ff, imag_step_ff;
   logic signed [DW-1:0] k_real_ff, k_imag_ff;
   logic [IB-1:0]        max_iter_ff;

   jetp_pkg::req_type    req_ff, req_in;
   logic signed [PW-1:0] px_prod_ff, px_prod_in, py_prod_ff, py_prod_in;
   logic signed [SW-1:0] zr_wide, zi_wide;
   logic signed [DW-1:0] z0_real, z0_imag;
   logic [IB-1:0]        k_ff, k_in;
   logic                 inside_ff, inside_in, hi_ff, hi_in;
   logic [QW-1:0]        q_ff, q_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_load;
   jetp_pkg::rsp_type    rsp_ff, rsp_in;

   jetp_pkg::core_ctl_type core_ctl;
   jetp_pkg::core_sts_type core_sts;

   logic                 div_start;
   logic [RW-1:0]        div_num;
   logic signed [IB+1:0] band_diff;
   logic                 div_valid [QW+1];
   logic [RW-1:0]        div_rem   [QW+1];
   logic [QW-1:0]        div_quot  [QW+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_real_ff  <= DW'(jetp_pkg::RESET_MIN_REAL);
         max_imag_ff  <= DW'(jetp_pkg::RESET_MAX_IMAG);
         real_step_ff <= DW'(jetp_pkg::RESET_REAL_STEP);
         imag_step_ff <= DW'(jetp_pkg::RESET_IMAG_STEP);
         k_real_ff    <= DW'(jetp_pkg::RESET_K_REAL);
         k_imag_ff    <= DW'(jetp_pkg::RESET_K_IMAG);
         max_iter_ff  <= IB'(jetp_pkg::RESET_MAX_ITER);
      end else if (csr_we) begin
         unique case (csr_addr)
            jetp_pkg::REG_MIN_REAL:  min_real_ff  <= csr_wdata[DW-1:0];
            jetp_pkg::REG_MAX_IMAG:  max_imag_ff  <= csr_wdata[DW-1:0];
            jetp_pkg::REG_REAL_STEP: real_step_ff <= csr_wdata[DW-1:0];
            jetp_pkg::REG_IMAG_STEP: imag_step_ff <= csr_wdata[DW-1:0];
            jetp_pkg::REG_K_REAL:    k_real_ff    <= csr_wdata[DW-1:0];
            jetp_pkg::REG_K_IMAG:    k_imag_ff    <= csr_wdata[DW-1:0];
            jetp_pkg::REG_MAX_ITER:  max_iter_ff  <= csr_wdata[IB-1:0];
            default: ;
         endcase
      end
   end

   // start point with saturation
   always_comb begin
      px_prod_in = PW'($signed({1'b0, req_ff.pixel_x})) * PW'(real_step_ff);
      py_prod_in = PW'($signed({1'b0, req_ff.pixel_y})) * PW'(imag_step_ff);
      zr_wide = SW'(min_real_ff) + SW'(px_prod_ff);
      zi_wide = SW'(max_imag_ff) - SW'(py_prod_ff);
      if (&zr_wide[SW-1:DW-1] || ~|zr_wide[SW-1:DW-1]) begin
         z0_real = zr_wide[DW-1:0];
      end else begin
         z0_real = zr_wide[SW-1] ? SAT_MIN : SAT_MAX;
      end
      if (&zi_wide[SW-1:DW-1] || ~|zi_wide[SW-1:DW-1]) begin
         z0_imag = zi_wide[DW-1:0];
      end else begin
         z0_imag = zi_wide[SW-1] ? SAT_MIN : SAT_MAX;
      end
   end

   jetp_core #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock   (clock),
      .ctl     (core_ctl),
      .z0_real (z0_real),
      .z0_imag (z0_imag),
      .k_real  (k_real_ff),
      .k_imag  (k_imag_ff),
      .sts     (core_sts)
   );

   // colour numerator
   always_comb begin
      band_diff = $signed({1'b0, k_ff, 1'b0}) - $signed({2'b00, max_iter_ff});
      if (hi_in) begin
         if (!band_diff[IB+1] && (band_diff != '0)) begin
            div_num = (RW'(band_diff) << 8) - RW'(band_diff);
         end else begin
            div_num = '0;
         end
      end else begin
         div_num = (RW'(k_ff) << 9) - (RW'(k_ff) << 1);
      end
   end

   assign div_valid[0] = div_start;
   assign div_rem[0]   = div_num;
   assign div_quot[0]  = '0;

   for (genvar i = 0; i < QW; i++) begin : g_div
      jetp_div_cell #(
         .BIT_POS (QW - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (div_valid[i]),
         .rem_in    (div_rem[i]),
         .quot_in   (div_quot[i]),
         .den       (max_iter_ff),
         .valid_out (div_valid[i+1]),
         .rem_out   (div_rem[i+1]),
         .quot_out  (div_quot[i+1])
      );
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      k_in          = k_ff;
      inside_in     = inside_ff;
      hi_in         = !(k_ff < (max_iter_ff >> 1));
      q_in          = q_ff;
      core_ctl.load = 1'b0;
      core_ctl.step = 1'b0;
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_COORD;
            end
         end
         S_COORD: state_in = S_LOAD;
         S_LOAD: begin
            core_ctl.load = 1'b1;
            k_in          = '0;
            state_in      = S_MUL;
         end
         S_MUL: state_in = S_CHK;
         S_CHK: begin
            priority if (k_ff >= max_iter_ff) begin
               inside_in = 1'b1;
               state_in  = S_OUT;
            end else if (core_sts.escape) begin
               inside_in = 1'b0;
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               core_ctl.step = 1'b1;
               k_in          = k_ff + 1'b1;
               state_in      = S_MUL;
            end
         end
         S_DIV: begin
            hi_in = hi_ff;
            if (div_valid[QW]) begin
               q_in     = div_quot[QW];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            hi_in = hi_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in.inside_res   = inside_ff;
      rsp_in.escape_count = k_ff;
      if (inside_ff) begin
         rsp_in.red   = '0;
         rsp_in.green = '0;
         rsp_in.blue  = '0;
      end else if (hi_ff) begin
         rsp_in.red   = q_ff;
         rsp_in.green = q_ff;
         rsp_in.blue  = 8'hFF;
      end else begin
         rsp_in.red   = '0;
         rsp_in.green = '0;
         rsp_in.blue  = q_ff;
      end
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      px_prod_ff <= px_prod_in;
      py_prod_ff <= py_prod_in;
      k_ff       <= k_in;
      inside_ff  <= inside_in;
      hi_ff      <= hi_in;
      q_ff       <= q_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `JETP_ASSERT_IMPLY(a_chk_after_mul, clock, reset, state_ff == S_CHK, $past(state_ff) == S_MUL)
   `JETP_ASSERT_IMPLY(a_count_bounded, clock, reset, state_ff == S_CHK, k_ff <= max_iter_ff)
   `JETP_ASSERT_IMPLY(a_tail_in_div, clock, reset, div_valid[QW], state_ff == S_DIV)
   `JETP_ASSERT_NEXT(a_div_to_out, clock, reset, state_ff == S_DIV && div_valid[QW], state_ff == S_OUT)

endmodule
